// ===== rtl/epoch_seconds_to_calendar_defines.svh =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar assertion macros
// shared assertion forms for the calendar conversion block
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ESC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("calendar conversion check failed");

// next-cycle implication, checked out of reset
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("calendar conversion check failed");

`endif

// ===== rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// constants, structs and the month length table for the calendar converter
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

	// field widths
	localparam int unsigned EpochW  = 31;
	localparam int unsigned YearW   = 11;
	localparam int unsigned MonthW  = 4;
	localparam int unsigned DayW    = 5;
	localparam int unsigned HourW   = 5;
	localparam int unsigned MinuteW = 6;
	localparam int unsigned SecW    = 6;

	// time constants in seconds
	localparam logic [EpochW-1:0] SecsCommonYear = 31'd31536000;
	localparam logic [EpochW-1:0] SecsLeapYear   = 31'd31622400;
	localparam logic [EpochW-1:0] SecsPerDay     = 31'd86400;
	localparam logic [EpochW-1:0] SecsPerHour    = 31'd3600;
	localparam logic [EpochW-1:0] SecsPerMinute  = 31'd60;
	localparam logic [YearW-1:0]  EpochYear      = 11'd1970;
	localparam logic [MonthW-1:0] MonthJan       = 4'd1;
	localparam logic [MonthW-1:0] MonthDec       = 4'd12;

	// operand pair into the shared compare-subtract unit
	typedef struct packed {
		logic [EpochW-1:0] rem;
		logic [EpochW-1:0] sub;
	} esc_alu_req_t;

	// compare-subtract result
	typedef struct packed {
		logic              ge;
		logic [EpochW-1:0] diff;
	} esc_alu_res_t;

	// finished calendar fields
	typedef struct packed {
		logic [YearW-1:0]   year;
		logic [MonthW-1:0]  month;
		logic [DayW-1:0]    day;
		logic [HourW-1:0]   hour;
		logic [MinuteW-1:0] minute;
		logic [SecW-1:0]    sec;
	} esc_result_t;

	// sequencer status towards the top level
	typedef struct packed {
		logic idle;
		logic done;
	} esc_status_t;

	// length of a month in seconds, february by the leap flag
	function automatic logic [EpochW-1:0] month_secs(input logic [MonthW-1:0] m,
		input logic leap);
		logic [EpochW-1:0] d;
		unique case (m)
			4'd2:    d = leap ? 31'd29 : 31'd28;
			4'd4:    d = 31'd30;
			4'd6:    d = 31'd30;
			4'd9:    d = 31'd30;
			4'd11:   d = 31'd30;
			default: d = 31'd31;
		endcase
		return EpochW'(d * SecsPerDay);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/esc_alu.sv =====
// ----------------------------------------------------------------------------
// esc_alu
// shared compare-subtract unit: remainder minus subtrahend with borrow out
// ----------------------------------------------------------------------------
`default_nettype none

module esc_alu
	import esc_pkg::*;
(
	input  esc_alu_req_t req,
	output esc_alu_res_t res
);

	logic [EpochW:0] diff_w;

	// one wide subtract, borrow gives the compare
	assign diff_w   = {1'b0, req.rem} - {1'b0, req.sub};
	assign res.ge   = ~diff_w[EpochW];
	assign res.diff = diff_w[EpochW-1:0];

endmodule

`default_nettype wire

// ===== rtl/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl
// sequencer: steps years, months, then restoring division for day, hour, minute
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ctrl
	import esc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [EpochW-1:0] epoch_in,
	input  logic              res_take,
	input  esc_alu_res_t      alu_res,
	output esc_alu_req_t      alu_req,
	output esc_status_t       status,
	output esc_result_t       result
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_YEAR  = 7'b0000010,
		ST_MONTH = 7'b0000100,
		ST_DAY   = 7'b0001000,
		ST_HOUR  = 7'b0010000,
		ST_MIN   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} esc_state_t;

	esc_state_t         state_q;
	logic [EpochW-1:0]  rem_q;
	logic [YearW-1:0]   year_q;
	logic [MonthW-1:0]  month_q;
	logic [MinuteW-1:0] quo_q;
	logic [2:0]         bit_q;
	logic [DayW-1:0]    day_q;
	logic [HourW-1:0]   hour_q;
	logic [MinuteW-1:0] min_q;
	logic               leap;
	logic [MinuteW-1:0] quo_next;

	// leap rule over the reachable years 1970..2038; the one century year
	// there, 2000, is also divisible by 400
	assign leap     = (year_q[1:0] == 2'b00);
	assign quo_next = {quo_q[MinuteW-2:0], alu_res.ge};

	// subtrahend selection for the shared unit
	always_comb begin
		alu_req.rem = rem_q;
		unique case (state_q)
			ST_YEAR:  alu_req.sub = leap ? SecsLeapYear : SecsCommonYear;
			ST_MONTH: alu_req.sub = month_secs(month_q, leap);
			ST_DAY:   alu_req.sub = SecsPerDay << bit_q;
			ST_HOUR:  alu_req.sub = SecsPerHour << bit_q;
			ST_MIN:   alu_req.sub = SecsPerMinute << bit_q;
			default:  alu_req.sub = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_YEAR;
				ST_YEAR:  if (!alu_res.ge) state_q <= ST_MONTH;
				ST_MONTH: if (month_q == MonthDec || !alu_res.ge) state_q <= ST_DAY;
				ST_DAY:   if (bit_q == 3'd0) state_q <= ST_HOUR;
				ST_HOUR:  if (bit_q == 3'd0) state_q <= ST_MIN;
				ST_MIN:   if (bit_q == 3'd0) state_q <= ST_DONE;
				ST_DONE:  if (res_take) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rem_q   <= epoch_in;
				year_q  <= EpochYear;
				month_q <= MonthJan;
				quo_q   <= '0;
				bit_q   <= 3'd4;
			end
			ST_YEAR: begin
				if (alu_res.ge) begin
					rem_q  <= alu_res.diff;
					year_q <= year_q + 11'd1;
				end
			end
			ST_MONTH: begin
				if (month_q != MonthDec && alu_res.ge) begin
					rem_q   <= alu_res.diff;
					month_q <= month_q + 4'd1;
				end
			end
			ST_DAY, ST_HOUR, ST_MIN: begin
				if (alu_res.ge) rem_q <= alu_res.diff;
				if (bit_q == 3'd0) begin
					quo_q <= '0;
					// minutes need six quotient bits
					bit_q <= state_q[4] ? 3'd5 : 3'd4;
					if (state_q[3]) day_q  <= quo_next[DayW-1:0] + 5'd1;
					if (state_q[4]) hour_q <= quo_next[HourW-1:0];
					if (state_q[5]) min_q  <= quo_next;
				end else begin
					quo_q <= quo_next;
					bit_q <= bit_q - 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign status.idle = state_q[0];
	assign status.done = state_q[6];

	assign result.year   = year_q;
	assign result.month  = month_q;
	assign result.day    = day_q;
	assign result.hour   = hour_q;
	assign result.minute = min_q;
	assign result.sec    = rem_q[SecW-1:0];

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar.sv =====
// steps from request to result: a year search of one step per whole year past 1970
// (up to 68) plus a closing step, a month search of one step per whole month (up to 11)
// plus a closing step, 16 fixed division steps for day, hour and minute, then a done state
// one request at a time, taken only when idle, since the single shared compare-subtract unit serves every step
// a finished result waits in the output register while the next request starts
// reset: arst_n clears the sequencer to idle and the output register to empty
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// converts seconds since 1970 into UTC year, month, day, hour, minute, second
// ----------------------------------------------------------------------------
`default_nettype none

`include "epoch_seconds_to_calendar_defines.svh"

module epoch_seconds_to_calendar
	import esc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [EpochW-1:0]  epoch_seconds,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [YearW-1:0]   year,
	output logic [MonthW-1:0]  month,
	output logic [DayW-1:0]    day,
	output logic [HourW-1:0]   hour,
	output logic [MinuteW-1:0] minute,
	output logic [SecW-1:0]    sec
);

	esc_alu_req_t alu_req;
	esc_alu_res_t alu_res;
	esc_status_t  status;
	esc_result_t  result;
	esc_result_t  out_q;
	logic         out_valid_q;
	logic         res_take;
	logic         start;

	assign in_ready = status.idle;
	assign start    = in_valid & status.idle;
	assign res_take = ~out_valid_q | out_ready;

	esc_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	esc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.epoch_in (epoch_seconds),
		.res_take (res_take),
		.alu_res  (alu_res),
		.alu_req  (alu_req),
		.status   (status),
		.result   (result)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.done && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (status.done && res_take) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign year      = out_q.year;
	assign month     = out_q.month;
	assign day       = out_q.day;
	assign hour      = out_q.hour;
	assign minute    = out_q.minute;
	assign sec       = out_q.sec;

	// checks
	`ESC_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready)
	`ESC_ASSERT_NOW(a_date_range, out_valid,
		month != 4'd0 && month <= MonthDec && day != 5'd0)
	`ESC_ASSERT_NOW(a_time_range, out_valid,
		hour < 5'd24 && minute < 6'd60 && sec < 6'd60)
	`ESC_ASSERT_NOW(a_one_job, status.done, !status.idle)

endmodule

`default_nettype wire
